// ----- rtl/core/tce_pkg.sv -----
// Types and constants for the tile cull emitter.
// No dependencies; compile first.
package tce_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CULL_ENABLE   = 3'd0;
    localparam logic [2:0] REG_VIEW_LEFT     = 3'd1;
    localparam logic [2:0] REG_VIEW_RIGHT    = 3'd2;
    localparam logic [2:0] REG_VIEW_BOTTOM   = 3'd3;
    localparam logic [2:0] REG_VIEW_TOP      = 3'd4;
    localparam logic [2:0] REG_TILE_SIZE     = 3'd5;
    localparam logic [2:0] REG_SHEET_COLUMNS = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Record kinds
    localparam logic KIND_TILE = 1'b0;
    localparam logic KIND_STAT = 1'b1;

    localparam logic [10:0] TILE_SIZE_MAX = 11'd1024;
    localparam logic [8:0]  SHEET_COL_MAX = 9'd256;
    localparam logic [3:0]  DIV_STEPS     = 4'd15;

    typedef struct packed {
        logic [9:0]         cell_x;
        logic [9:0]         cell_y;
        logic signed [15:0] tile_id;
        logic               frame_end;
    } cell_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  tile_col;
        logic [9:0]  tile_row;
        logic [19:0] pos_x;
        logic [19:0] pos_y;
        logic [7:0]  sheet_col;
        logic [14:0] sheet_row;
        logic [20:0] total_count;
        logic [20:0] visible_count;
    } tile_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic check;
        logic div_start;
        logic clr_counts;
        logic sel_stat;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic visible;
        logic last;
        logic div_busy;
    } status_t;

endpackage

// ----- rtl/core/tce_if.sv -----
// Valid/ready stream interfaces for map cells and emitted records.
// Depends on tce_pkg for the payload types.
interface tce_cell_if import tce_pkg::*; ();
    logic  valid;
    logic  ready;
    cell_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tce_tile_if import tce_pkg::*; ();
    logic  valid;
    logic  ready;
    tile_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/tce_div.sv -----
// Radix-2 restoring divider: 15-bit dividend by 9-bit divisor, one bit a cycle.
// Depends on tce_pkg for the step count.
module tce_div import tce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [14:0] dividend,
    input  logic [8:0]  divisor,
    output logic        busy,
    output logic [14:0] quotient,
    output logic [8:0]  remainder
);

    logic [3:0]  cnt_reg, cnt_next;
    logic [8:0]  rem_reg, rem_next;
    logic [14:0] quo_reg, quo_next;
    logic [8:0]  dsr_reg, dsr_next;
    logic [9:0]  rem_sh;
    logic        ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[14]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = DIV_STEPS;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != 4'd0)
        begin
            cnt_next = cnt_reg - 4'd1;
            // remainder stays below the divisor, so it fits 9 bits either way
            rem_next = ge ? 9'(rem_sh - {1'b0, dsr_reg}) : rem_sh[8:0];
            quo_next = {quo_reg[13:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = cnt_reg != 4'd0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/tce_dpath.sv -----
// Datapath: configuration registers, cell capture, position multiply, window
// test, frame counters, tileset divider and record assembly. Uses tce_pkg, tce_div.
module tce_dpath import tce_pkg::*;
#(
    parameter int MAX_MAP_SIDE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cell_t                 cell_item,
    input  cmd_t                  cmd,
    output status_t               status,
    output tile_t                 record
);

    localparam longint MapCells = longint'(MAX_MAP_SIDE) * longint'(MAX_MAP_SIDE);
    localparam logic [20:0] CountLimit =
        (MapCells > 64'sd2097151) ? 21'h1FFFFF : 21'(MapCells);

    // Configuration
    logic               cull_reg;
    logic signed [23:0] left_reg, right_reg, bottom_reg, top_reg;
    logic [10:0]        size_reg;
    logic [8:0]         cols_reg;

    // Cell and working registers
    cell_t              cell_reg;
    logic [20:0]        px_reg, py_reg;
    logic [20:0]        total_reg, total_next;
    logic [20:0]        vis_reg, vis_next;

    logic [10:0]        size_eff;
    logic [8:0]         cols_eff;
    logic               nonempty;
    logic               in_x, in_y, visible;
    logic [20:0]        px_plus, py_plus;
    logic signed [21:0] px_minus, py_minus;
    logic signed [29:0] x_lo_edge, x_hi_edge, y_lo_edge, y_hi_edge;
    logic signed [29:0] left_ext, right_ext, bottom_ext, top_ext;
    logic [14:0]        quo;
    logic [8:0]         rem;
    logic               div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cull_reg   <= 1'b0;
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            top_reg    <= '0;
            size_reg   <= 11'd16;
            cols_reg   <= 9'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CULL_ENABLE:   cull_reg   <= cfg_data[0];
                REG_VIEW_LEFT:     left_reg   <= cfg_data;
                REG_VIEW_RIGHT:    right_reg  <= cfg_data;
                REG_VIEW_BOTTOM:   bottom_reg <= cfg_data;
                REG_VIEW_TOP:      top_reg    <= cfg_data;
                REG_TILE_SIZE:     size_reg   <= cfg_data[10:0];
                REG_SHEET_COLUMNS: cols_reg   <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    assign size_eff = (size_reg > TILE_SIZE_MAX) ? TILE_SIZE_MAX : size_reg;
    assign cols_eff = (cols_reg == 9'd0) ? 9'd1 :
                      ((cols_reg > SHEET_COL_MAX) ? SHEET_COL_MAX : cols_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cell_reg <= cell_item;
        end
        if (cmd.mul)
        begin
            px_reg <= {11'd0, cell_reg.cell_x} * {10'd0, size_eff};
            py_reg <= {11'd0, cell_reg.cell_y} * {10'd0, size_eff};
        end
    end

    // Window test without division, with d = size*256:
    //   x >= floor(L/d)  <=>  L < (x+1)*d ;  x <= ceil(R/d)  <=>  R > (x-1)*d
    assign px_plus   = px_reg + 21'(size_eff);
    assign py_plus   = py_reg + 21'(size_eff);
    assign px_minus  = $signed({1'b0, px_reg}) - $signed({11'd0, size_eff});
    assign py_minus  = $signed({1'b0, py_reg}) - $signed({11'd0, size_eff});
    assign x_lo_edge = $signed({1'b0, px_plus, 8'h00});
    assign y_lo_edge = $signed({1'b0, py_plus, 8'h00});
    assign x_hi_edge = $signed({px_minus, 8'h00});
    assign y_hi_edge = $signed({py_minus, 8'h00});
    assign left_ext   = 30'(left_reg);
    assign right_ext  = 30'(right_reg);
    assign bottom_ext = 30'(bottom_reg);
    assign top_ext    = 30'(top_reg);

    assign in_x     = (left_ext < x_lo_edge) && (right_ext > x_hi_edge);
    assign in_y     = (bottom_ext < y_lo_edge) && (top_ext > y_hi_edge);
    assign nonempty = (size_eff != 11'd0) && !cell_reg.tile_id[15]
                      && (cell_reg.tile_id != 16'sd0);
    assign visible  = nonempty && (!cull_reg || (in_x && in_y));

    always_comb
    begin
        total_next = total_reg;
        vis_next   = vis_reg;
        if (cmd.clr_counts)
        begin
            total_next = '0;
            vis_next   = '0;
        end
        else if (cmd.check)
        begin
            if (nonempty && total_reg < CountLimit)
            begin
                total_next = total_reg + 21'd1;
            end
            if (visible && vis_reg < CountLimit)
            begin
                vis_next = vis_reg + 21'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            vis_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            vis_reg   <= vis_next;
        end
    end

    tce_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (15'(cell_reg.tile_id - 16'sd1)),
        .divisor   (cols_eff),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    assign status.visible  = visible;
    assign status.last     = cell_reg.frame_end;
    assign status.div_busy = div_busy;

    always_comb
    begin
        record = '0;
        if (cmd.sel_stat)
        begin
            record.kind          = KIND_STAT;
            record.total_count   = total_reg;
            record.visible_count = vis_reg;
        end
        else
        begin
            record.kind      = KIND_TILE;
            record.tile_col  = cell_reg.cell_x;
            record.tile_row  = cell_reg.cell_y;
            record.pos_x     = px_reg[19:0];
            record.pos_y     = py_reg[19:0];
            record.sheet_col = rem[7:0];
            record.sheet_row = quo;
        end
    end

endmodule

// ----- rtl/core/tce_ctrl.sv -----
// Controller state machine: sequences capture, multiply, test, divide and
// the two record kinds. Uses tce_pkg for command and status types.
module tce_ctrl import tce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_TILE = 3'd4;
    localparam logic [2:0] S_STAT = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.check = 1'b1;
                if (status.visible)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.last)
                begin
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_TILE;
                end
            end
            S_TILE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = status.last ? S_STAT : S_IDLE;
                end
            end
            S_STAT:
            begin
                out_valid    = 1'b1;
                cmd.sel_stat = 1'b1;
                if (out_ready)
                begin
                    // drop the counts once the statistics transaction completes
                    cmd.clr_counts = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/tilemap_cull_tile_emitter.sv -----
// Top level of the tile cull emitter: controller plus datapath.
// Depends on tce_pkg, tce_if, tce_ctrl, tce_dpath (and tce_div below it).
//
//   port      | dir | payload | role
//   ----------+-----+---------+-----------------------------------------
//   cell_in   | in  | cell_t  | map cells in row-major order
//   tile_out  | out | tile_t  | tile records and end-of-frame statistics
//   cfg_*     | in  | 24 bit  | register writes, index 0..6
//
// A cell is taken only in the idle state. A hidden or empty cell passes capture,
// multiply and window test; a visible cell then waits in the divide state for the
// bit-serial divider to finish its 15 quotient steps, then presents the tile record.
// The frame-end cell then adds a statistics record. Stalls on tile_out hold the record
// and the block. Reset clears the counters and loads register defaults.
module tilemap_cull_tile_emitter import tce_pkg::*;
#(
    parameter int MAX_MAP_SIDE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tce_cell_if.sink              cell_in,
    tce_tile_if.source            tile_out
);

    cmd_t    cmd;
    status_t status;

    tce_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_in.valid),
        .in_ready  (cell_in.ready),
        .out_valid (tile_out.valid),
        .out_ready (tile_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tce_dpath #(
        .MAX_MAP_SIDE (MAX_MAP_SIDE)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_item (cell_in.payload),
        .cmd       (cmd),
        .status    (status),
        .record    (tile_out.payload)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tilemap_cull_tile_emitter: row-major map scans and noise cells
// go in, tile and frame statistics records are checked against an in-bench prediction.
// Depends on tce_pkg, tce_if and the emitter RTL.
module tb_top;
    import tce_pkg::*;

    localparam int MAP_SIDE    = 1024;
    localparam int COUNT_CAP   = (MAP_SIDE * MAP_SIDE > 2097151) ? 2097151
                                                                 : MAP_SIDE * MAP_SIDE;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 30;
    localparam int HOLD_LEN    = 300;
    localparam int N_CELLS     = 1650;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tce_cell_if cell_bus ();
    tce_tile_if tile_bus ();

    tilemap_cull_tile_emitter #(.MAX_MAP_SIDE(MAP_SIDE)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_in   (cell_bus),
        .tile_out  (tile_bus)
    );

    // Shadow of the register file and the frame counters
    bit          cull_on      = 1'b0;
    int          view_l       = 0;
    int          view_r       = 0;
    int          view_b       = 0;
    int          view_t       = 0;
    logic [10:0] size_reg     = 11'd16;
    logic [8:0]  cols_reg     = 9'd16;
    logic [20:0] nonempty_cnt = '0;
    logic [20:0] visible_cnt  = '0;

    cell_t cell_queue[$];
    tile_t expected_tiles[$];
    tile_t want_rec;

    int fail_count    = 0;
    int cycle_count   = 0;
    int counted_cells = 0;
    bit cell_taken    = 1'b0;
    int src_gap       = 0;
    int sink_gap      = 0;
    int hold_left     = 0;
    bit src_gaps_on   = 1'b1;
    bit sink_gaps_on  = 1'b1;
    bit hold_toggle   = 1'b0;
    bit hold_seen     = 1'b0;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic int floor_div(int a, int d);
        int q;
        q = a / d;
        if (a % d != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int ceil_div(int a, int d);
        int q;
        q = a / d;
        if (a % d != 0 && a > 0)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [20:0] bump(logic [20:0] c);
        return (c < COUNT_CAP) ? c + 21'd1 : c;
    endfunction

    function automatic void predict_cell(cell_t c);
        int    sz;
        int    cols;
        int    cx;
        int    cy;
        int    id;
        int    d;
        int    lo_x;
        int    hi_x;
        int    lo_y;
        int    hi_y;
        bit    shown;
        tile_t rec;
        sz   = (size_reg > TILE_SIZE_MAX) ? TILE_SIZE_MAX : size_reg;
        cols = (cols_reg == 0) ? 1 : ((cols_reg > SHEET_COL_MAX) ? SHEET_COL_MAX : cols_reg);
        cx   = c.cell_x;
        cy   = c.cell_y;
        id   = $signed(c.tile_id);
        if (sz != 0 && id > 0)
        begin
            nonempty_cnt = bump(nonempty_cnt);
            shown = 1'b1;
            if (cull_on)
            begin
                d    = sz * 256;
                lo_x = floor_div(view_l, d);
                hi_x = ceil_div(view_r, d);
                lo_y = floor_div(view_b, d);
                hi_y = ceil_div(view_t, d);
                if (lo_x < 0)
                    lo_x = 0;
                if (lo_y < 0)
                    lo_y = 0;
                shown = cx >= lo_x && cx <= hi_x && cy >= lo_y && cy <= hi_y;
            end
            if (shown)
            begin
                visible_cnt   = bump(visible_cnt);
                rec           = '0;
                rec.kind      = KIND_TILE;
                rec.tile_col  = c.cell_x;
                rec.tile_row  = c.cell_y;
                rec.pos_x     = 20'(cx * sz);
                rec.pos_y     = 20'(cy * sz);
                rec.sheet_col = 8'((id - 1) % cols);
                rec.sheet_row = 15'((id - 1) / cols);
                expected_tiles.push_back(rec);
            end
        end
        if (c.frame_end)
        begin
            rec               = '0;
            rec.kind          = KIND_STAT;
            rec.total_count   = nonempty_cnt;
            rec.visible_count = visible_cnt;
            expected_tiles.push_back(rec);
            nonempty_cnt = '0;
            visible_cnt  = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_cell(int x, int y, int id, bit fe);
        cell_t c;
        c.cell_x    = 10'(x);
        c.cell_y    = 10'(y);
        c.tile_id   = 16'(id);
        c.frame_end = fe;
        cell_queue.push_back(c);
        counted_cells++;
    endfunction

    function automatic int pick_id();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 0;
        if (r < 6)
            return 0 - int'($urandom_range(1, 32768));
        if (r < 12)
            return $urandom_range(1, 600);
        return $urandom_range(1, 32767);
    endfunction

    // Bound in Q15.8 near a tile edge; sometimes a rail or fully random value
    function automatic int view_near(int tile, int sz);
        logic [23:0] raw;
        longint      v;
        int          off;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return -8388608;
        if (r == 1)
            return 8388607;
        if (r == 2)
        begin
            raw = 24'($urandom);
            return $signed(raw);
        end
        off = 0;
        if (r > 5)
            off = int'($urandom_range(0, 2 * sz * 256 - 2)) - (sz * 256 - 1);
        v = longint'(tile) * sz * 256 + off;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return int'(v);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        logic [CFG_DATA_W-1:0] v;
        v = 24'(value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            REG_CULL_ENABLE:   cull_on  = v[0];
            REG_VIEW_LEFT:     view_l   = $signed(v);
            REG_VIEW_RIGHT:    view_r   = $signed(v);
            REG_VIEW_BOTTOM:   view_b   = $signed(v);
            REG_VIEW_TOP:      view_t   = $signed(v);
            REG_TILE_SIZE:     size_reg = v[10:0];
            REG_SHEET_COLUMNS: cols_reg = v[8:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int cull, int l, int r, int b, int t, int sz, int cols);
        write_reg(REG_CULL_ENABLE, cull);
        write_reg(REG_VIEW_LEFT, l);
        write_reg(REG_VIEW_RIGHT, r);
        write_reg(REG_VIEW_BOTTOM, b);
        write_reg(REG_VIEW_TOP, t);
        write_reg(REG_TILE_SIZE, sz);
        write_reg(REG_SHEET_COLUMNS, cols);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every cell is in and every record is out, then let hidden cells finish
    task automatic wait_drained();
        while (cell_queue.size() != 0 || cell_bus.valid || expected_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cell driver
    always @(negedge clk)
    begin
        if (!(cell_bus.valid && !cell_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                cell_bus.valid <= 1'b0;
            end
            else if (cell_queue.size() != 0)
            begin
                cell_bus.payload <= cell_queue.pop_front();
                cell_bus.valid   <= 1'b1;
                if (src_gaps_on)
                    src_gap = draw_gap();
            end
            else
                cell_bus.valid <= 1'b0;
        end
    end

    // Record sink: random stalls plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            tile_bus.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            tile_bus.ready <= 1'b0;
        end
        else
        begin
            tile_bus.ready <= 1'b1;
            if (sink_gaps_on)
                sink_gap = draw_gap();
        end
    end

    // Predict on each accepted cell, check each accepted record
    always @(posedge clk)
    begin
        cell_taken <= cell_bus.valid && cell_bus.ready;
        if (rst_n)
        begin
            if (cell_bus.valid && cell_bus.ready)
                predict_cell(cell_bus.payload);
            if (tile_bus.valid && tile_bus.ready)
            begin
                if (expected_tiles.size() == 0)
                begin
                    $error("record with no expectation: kind %0d", tile_bus.payload.kind);
                    fail_count++;
                end
                else
                begin
                    want_rec = expected_tiles.pop_front();
                    check_field("kind", want_rec.kind, tile_bus.payload.kind);
                    check_field("tile_col", want_rec.tile_col, tile_bus.payload.tile_col);
                    check_field("tile_row", want_rec.tile_row, tile_bus.payload.tile_row);
                    check_field("pos_x", want_rec.pos_x, tile_bus.payload.pos_x);
                    check_field("pos_y", want_rec.pos_y, tile_bus.payload.pos_y);
                    check_field("sheet_col", want_rec.sheet_col, tile_bus.payload.sheet_col);
                    check_field("sheet_row", want_rec.sheet_row, tile_bus.payload.sheet_row);
                    check_field("total_count", want_rec.total_count,
                                tile_bus.payload.total_count);
                    check_field("visible_count", want_rec.visible_count,
                                tile_bus.payload.visible_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[tilemap_cull_tile_emitter] ERROR");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int sz;
        int sz_eff;
        int cols;
        int w;
        int h;
        int x0;
        int y0;
        int lim;
        int n;
        int k;
        int issued;
        int target;
        bit drop_end;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cell_bus.valid   = 1'b0;
        cell_bus.payload = '0;
        tile_bus.ready   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset values: id extremes, empty and negative ids, frame end with and without a tile
        push_cell(0, 0, 1, 1'b0);
        push_cell(1023, 1023, 32767, 1'b0);
        push_cell(5, 5, 0, 1'b0);
        push_cell(6, 6, -32768, 1'b0);
        push_cell(7, 7, -1, 1'b0);
        push_cell(3, 4, 17, 1'b1);
        push_cell(2, 2, 0, 1'b1);
        wait_drained();

        // Window cols 0..4 (left clamped), rows 2..5 exactly on tile edges
        write_all(1, -5000, 3 * 4096 + 1, 2 * 4096, 5 * 4096, 16, 7);
        push_cell(0, 2, 8, 1'b0);
        push_cell(4, 5, 9, 1'b0);
        push_cell(5, 5, 10, 1'b0);
        push_cell(4, 1, 11, 1'b0);
        push_cell(2, 6, 12, 1'b0);
        push_cell(1, 3, 0, 1'b1);
        wait_drained();

        // Empty window, oversize tile clamp, zero sheet columns
        write_all(1, 8388607, -8388608, 8388607, -8388608, 2047, 0);
        push_cell(0, 0, 5, 1'b0);
        push_cell(1, 1, 6, 1'b1);
        wait_drained();

        write_all(0, -8388608, 8388607, -8388608, 8388607, 2047, 511);
        push_cell(1023, 1023, 32767, 1'b0);
        push_cell(512, 256, 257, 1'b1);
        wait_drained();

        // Zero tile size: map ignored, statistics still emitted
        write_all(1, 0, 0, 0, 0, 0, 1);
        push_cell(3, 3, 100, 1'b0);
        push_cell(0, 0, 1, 1'b1);
        wait_drained();

        write_all(1, -8388608, 8388607, -8388608, 8388607, 1, 256);
        push_cell(1023, 0, 256, 1'b0);
        push_cell(0, 1023, 257, 1'b1);
        wait_drained();

        counted_cells = 0;
        for (ph = 0; counted_cells < N_CELLS; ph++)
        begin
            case ($urandom_range(0, 9))
                0: sz = 1;
                1: sz = 2;
                2: sz = 16;
                3: sz = 1023;
                4: sz = 1024;
                5: sz = 2047;
                6: sz = ($urandom_range(0, 2) == 0) ? 0 : 8;
                7: sz = $urandom_range(1, 2047);
                default: sz = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 7))
                0: cols = 0;
                1: cols = 1;
                2: cols = 2;
                3: cols = 255;
                4: cols = 256;
                5: cols = 511;
                6: cols = $urandom_range(0, 511);
                default: cols = $urandom_range(1, 40);
            endcase
            sz_eff = (sz == 0) ? 1 : ((sz > 1024) ? 1024 : sz);
            w      = $urandom_range(1, 12);
            h      = $urandom_range(1, 6);
            lim    = 8388607 / (sz_eff * 256);
            x0     = $urandom_range(0, (lim < 1024 - w) ? lim : 1024 - w);
            y0     = $urandom_range(0, (lim < 1024 - h) ? lim : 1024 - h);
            write_all($urandom_range(0, 3) != 0,
                      view_near(x0 + int'($urandom_range(0, w)) - 1, sz_eff),
                      view_near(x0 + int'($urandom_range(0, w)), sz_eff),
                      view_near(y0 + int'($urandom_range(0, h)) - 1, sz_eff),
                      view_near(y0 + int'($urandom_range(0, h)), sz_eff),
                      sz, cols);

            src_gaps_on  = (ph % 3 != 0);
            sink_gaps_on = (ph % 4 != 1);
            if (ph == 2 || ph == 7)
                hold_toggle = ~hold_toggle;

            // Mostly whole scans of the region; some truncated, some missing frame end, some noise
            issued = 0;
            target = counted_cells + 150;
            while (counted_cells < target && issued < 400)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    push_cell($urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 65535), $urandom_range(0, 9) == 0);
                    issued++;
                end
                else
                begin
                    n = w * h;
                    if ($urandom_range(0, 9) == 0)
                        n = $urandom_range(1, w * h);
                    drop_end = ($urandom_range(0, 14) == 0);
                    for (k = 0; k < n; k++)
                        push_cell(x0 + k % w, y0 + k / w, pick_id(), k == n - 1 && !drop_end);
                    issued += n;
                end
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("[tilemap_cull_tile_emitter] OK");
        else
            $display("[tilemap_cull_tile_emitter] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tce_pkg.sv
rtl/core/tce_if.sv
rtl/core/tce_div.sv
rtl/core/tce_dpath.sv
rtl/core/tce_ctrl.sv
rtl/core/tilemap_cull_tile_emitter.sv
verif/tb_top.sv
